// File: rtl/core/acr_pkg.sv
// Shared types and constants of the box collision resolver.
package acr_pkg;

	localparam int IN_COORD_BITS = 16;
	localparam int POS_BITS = 16;
	localparam int SIZE_BITS = 12;
	localparam int VEL_BITS = 8;
	localparam int OP_BITS = 2;
	localparam int TILE_BITS = 8;
	localparam int MAP_BITS = 10;
	localparam int WORLD_BITS = TILE_BITS + MAP_BITS;
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 10;

	localparam logic [OP_BITS-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_BITS-1:0] OP_OBST = 2'd1;
	localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

	localparam logic [CFG_ADDR_BITS-1:0] CFG_TILE_PIXELS = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_MAP_COLUMNS = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_MAP_ROWS = 2'd2;

	localparam logic [TILE_BITS-1:0] TILE_PIXELS_RESET = 8'd10;

	typedef struct packed {
		logic load;
		logic begin_step;
		logic obst_x;
		logic obst_y;
		logic world_mul;
		logic clamp;
	} dp_cmd_t;

endpackage

// File: rtl/core/acr_ctrl.sv
// Sequencing controller of the box collision resolver.
module acr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [acr_pkg::OP_BITS-1:0]  op,
	output logic                         busy,
	output acr_pkg::dp_cmd_t             cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BEGIN,
		S_OBST_X,
		S_OBST_Y,
		S_WMUL,
		S_CLAMP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (op)
							acr_pkg::OP_BEGIN:  state_q <= S_BEGIN;
							acr_pkg::OP_OBST:   state_q <= S_OBST_X;
							acr_pkg::OP_FINISH: state_q <= S_WMUL;
							default:            state_q <= S_IDLE;
						endcase
					end
				end
				S_BEGIN:  state_q <= S_IDLE;
				S_OBST_X: state_q <= S_OBST_Y;
				S_OBST_Y: state_q <= S_IDLE;
				S_WMUL:   state_q <= S_CLAMP;
				S_CLAMP:  state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.load = start && (state_q == S_IDLE);
		cmd.begin_step = (state_q == S_BEGIN);
		cmd.obst_x = (state_q == S_OBST_X);
		cmd.obst_y = (state_q == S_OBST_Y);
		cmd.world_mul = (state_q == S_WMUL);
		cmd.clamp = (state_q == S_CLAMP);
	end

`ifndef SYNTHESIS
	a_obst_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == acr_pkg::OP_OBST) |=> (state_q == S_OBST_X))
		else $error("obstacle transfer did not start the X step");
	a_obst_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OBST_X) |=> (state_q == S_OBST_Y))
		else $error("Y step did not follow the X step");
	a_finish_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WMUL) |=> (state_q == S_CLAMP))
		else $error("clamp step did not follow the world size step");
`endif

endmodule

// File: rtl/core/acr_datapath.sv
// Datapath of the box collision resolver: box state, overlap tests and world clamp.
module acr_datapath #(
	parameter int COORD_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  acr_pkg::dp_cmd_t                        cmd,
	input  logic signed [acr_pkg::IN_COORD_BITS-1:0] box_x,
	input  logic signed [acr_pkg::IN_COORD_BITS-1:0] box_y,
	input  logic [acr_pkg::SIZE_BITS-1:0]           box_w,
	input  logic [acr_pkg::SIZE_BITS-1:0]           box_h,
	input  logic signed [acr_pkg::VEL_BITS-1:0]     vel_x_in,
	input  logic signed [acr_pkg::VEL_BITS-1:0]     vel_y_in,
	input  logic                                    cfg_we,
	input  logic [acr_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
	input  logic [acr_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
	output logic                                    done,
	output logic signed [acr_pkg::POS_BITS-1:0]     pos_x,
	output logic signed [acr_pkg::POS_BITS-1:0]     pos_y,
	output logic signed [acr_pkg::VEL_BITS-1:0]     vel_x_out,
	output logic signed [acr_pkg::VEL_BITS-1:0]     vel_y_out,
	output logic                                    hit
);

	localparam int CW = COORD_BITS;
	localparam int EW = ((CW > acr_pkg::WORLD_BITS + 2) ? CW : acr_pkg::WORLD_BITS + 2) + 4;
	localparam int SW = acr_pkg::SIZE_BITS;
	localparam int VW = acr_pkg::VEL_BITS;
	localparam int IW = acr_pkg::IN_COORD_BITS;
	localparam int WB = acr_pkg::WORLD_BITS;

	typedef logic signed [EW-1:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [VW-1:0] vel_t;
	typedef logic [SW-1:0] size_t;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam wide_t ZERO_W = '0;
	localparam coord_t ZERO_C = '0;
	localparam vel_t ZERO_V = '0;

	function automatic wide_t ext_c(input coord_t v);
		return {{(EW-CW){v[CW-1]}}, v};
	endfunction

	function automatic wide_t ext_i(input logic signed [IW-1:0] v);
		return {{(EW-IW){v[IW-1]}}, v};
	endfunction

	function automatic wide_t ext_v(input vel_t v);
		return {{(EW-VW){v[VW-1]}}, v};
	endfunction

	function automatic wide_t ext_s(input size_t v);
		return {{(EW-SW){1'b0}}, v};
	endfunction

	function automatic wide_t ext_w(input logic [WB-1:0] v);
		return {{(EW-WB){1'b0}}, v};
	endfunction

	function automatic coord_t sat(input wide_t v);
		coord_t r;
		if (v > ext_c(CMAX)) begin
			r = CMAX;
		end else if (v < ext_c(CMIN)) begin
			r = CMIN;
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	logic [acr_pkg::TILE_BITS-1:0] tile_pixels_q;
	logic [acr_pkg::MAP_BITS-1:0]  map_columns_q;
	logic [acr_pkg::MAP_BITS-1:0]  map_rows_q;

	coord_t bx_q, by_q;
	size_t  bw_q, bh_q;
	vel_t   vx_in_q, vy_in_q;

	coord_t pred_x_q, pred_y_q, cur_x_q, cur_y_q;
	size_t  mov_w_q, mov_h_q;
	vel_t   vel_x_q, vel_y_q;
	logic   hit_q, full_q;
	logic [WB-1:0] world_w_q, world_h_q;

	coord_t pred_x_d, pred_y_d, cur_x_d, cur_y_d;
	size_t  mov_w_d, mov_h_d;
	vel_t   vel_x_d, vel_y_d;
	logic   hit_d, full_d, yhit;

	logic signed [acr_pkg::POS_BITS-1:0] pos_x_q, pos_y_q;
	vel_t   vel_x_out_q, vel_y_out_q;
	logic   hit_out_q, done_q;

	wide_t px, py, cx, cy, w, h, bx, by, bw, bh, ww, wh, cx_ext, cy_ext;
	logic  ox_p, oy_p, oy_c, ox_c;
	logic  vx_pos, vx_neg, vy_pos, vy_neg;

	always_comb begin
		px = ext_c(pred_x_q);
		py = ext_c(pred_y_q);
		cx = ext_c(cur_x_q);
		cy = ext_c(cur_y_q);
		w = ext_s(mov_w_q);
		h = ext_s(mov_h_q);
		bx = ext_c(bx_q);
		by = ext_c(by_q);
		bw = ext_s(bw_q);
		bh = ext_s(bh_q);
		ww = ext_w(world_w_q);
		wh = ext_w(world_h_q);
		ox_p = (px + w > bx) && (px < bx + bw);
		oy_p = (py + h > by) && (py < by + bh);
		oy_c = (cy + h > by) && (cy < by + bh);
		ox_c = (cx + w > bx) && (cx < bx + bw);
		vx_pos = !vel_x_q[VW-1] && (vel_x_q != ZERO_V);
		vx_neg = vel_x_q[VW-1];
		vy_pos = !vel_y_q[VW-1] && (vel_y_q != ZERO_V);
		vy_neg = vel_y_q[VW-1];
	end

	always_comb begin
		pred_x_d = pred_x_q;
		pred_y_d = pred_y_q;
		cur_x_d = cur_x_q;
		cur_y_d = cur_y_q;
		mov_w_d = mov_w_q;
		mov_h_d = mov_h_q;
		vel_x_d = vel_x_q;
		vel_y_d = vel_y_q;
		hit_d = hit_q;
		full_d = full_q;
		yhit = full_q && ox_c && oy_p;

		if (cmd.begin_step) begin
			cur_x_d = bx_q;
			cur_y_d = by_q;
			mov_w_d = bw_q;
			mov_h_d = bh_q;
			vel_x_d = vx_in_q;
			vel_y_d = vy_in_q;
			pred_x_d = sat(bx + ext_v(vx_in_q));
			pred_y_d = sat(by + ext_v(vy_in_q));
			hit_d = 1'b0;
		end

		if (cmd.obst_x) begin
			full_d = ox_p && oy_p;
			if (ox_p && oy_p && oy_c) begin
				if (vx_pos) begin
					vel_x_d = ZERO_V;
					cur_x_d = sat(bx - w);
				end else if (vx_neg) begin
					vel_x_d = ZERO_V;
					cur_x_d = sat(bx + bw);
				end
				hit_d = 1'b1;
			end
		end

		if (cmd.obst_y) begin
			if (yhit) begin
				if (vy_pos) begin
					vel_y_d = ZERO_V;
					cur_y_d = sat(by - h);
				end else if (vy_neg) begin
					vel_y_d = ZERO_V;
					cur_y_d = sat(by + bh);
				end
				hit_d = 1'b1;
			end
			// A corner-only contact blocks X, but only when nothing was hit before.
			if (full_q && !hit_q && !yhit) begin
				vel_x_d = ZERO_V;
				hit_d = 1'b1;
			end
		end

		if (cmd.clamp) begin
			if (vx_neg) begin
				if (px <= ZERO_W) begin
					vel_x_d = ZERO_V;
					cur_x_d = ZERO_C;
					hit_d = 1'b1;
				end
			end else if (vx_pos) begin
				if (px + w >= ww) begin
					vel_x_d = ZERO_V;
					cur_x_d = sat(ww - w);
					hit_d = 1'b1;
				end
			end
			if (vy_neg) begin
				if (py <= ZERO_W) begin
					vel_y_d = ZERO_V;
					cur_y_d = ZERO_C;
					hit_d = 1'b1;
				end
			end else if (vy_pos) begin
				if (py + h >= wh) begin
					vel_y_d = ZERO_V;
					cur_y_d = sat(wh - h);
					hit_d = 1'b1;
				end
			end
		end

		cx_ext = ext_c(cur_x_d);
		cy_ext = ext_c(cur_y_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_pixels_q <= acr_pkg::TILE_PIXELS_RESET;
			map_columns_q <= '0;
			map_rows_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				acr_pkg::CFG_TILE_PIXELS: tile_pixels_q <= cfg_wdata[acr_pkg::TILE_BITS-1:0];
				acr_pkg::CFG_MAP_COLUMNS: map_columns_q <= cfg_wdata[acr_pkg::MAP_BITS-1:0];
				acr_pkg::CFG_MAP_ROWS:    map_rows_q <= cfg_wdata[acr_pkg::MAP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bx_q <= sat(ext_i(box_x));
			by_q <= sat(ext_i(box_y));
			bw_q <= box_w;
			bh_q <= box_h;
			vx_in_q <= vel_x_in;
			vy_in_q <= vel_y_in;
		end
		if (cmd.world_mul) begin
			world_w_q <= WB'(map_columns_q) * WB'(tile_pixels_q);
			world_h_q <= WB'(map_rows_q) * WB'(tile_pixels_q);
		end
		if (cmd.clamp) begin
			pos_x_q <= cx_ext[acr_pkg::POS_BITS-1:0];
			pos_y_q <= cy_ext[acr_pkg::POS_BITS-1:0];
			vel_x_out_q <= vel_x_d;
			vel_y_out_q <= vel_y_d;
			hit_out_q <= hit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_x_q <= '0;
			pred_y_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			mov_w_q <= '0;
			mov_h_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pred_x_q <= pred_x_d;
			pred_y_q <= pred_y_d;
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
			mov_w_q <= mov_w_d;
			mov_h_q <= mov_h_d;
			vel_x_q <= vel_x_d;
			vel_y_q <= vel_y_d;
			hit_q <= hit_d;
			full_q <= full_d;
			done_q <= cmd.clamp;
		end
	end

	assign done = done_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign vel_x_out = vel_x_out_q;
	assign vel_y_out = vel_y_out_q;
	assign hit = hit_out_q;

`ifndef SYNTHESIS
	a_done_after_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.clamp))
		else $error("result strobe without a preceding clamp step");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");
`endif

endmodule

// File: rtl/core/aabb_collision_resolver_top.sv
// Top level of the axis-separated box collision resolver.
//
// An item is transferred at a rising edge with start high and busy low. The op
// port selects begin (load the moving box and its velocity), obstacle (test one
// obstacle box and resolve X then Y), or finish (clamp to the world and emit).
// The unused op code is taken and does nothing. The obstacle X and Y steps run
// one after the other in the overlap logic, and finish forms the world size in
// the tile multiplier ahead of the clamp step. A finish item shows its result
// once the clamp step registers it: done is high for one cycle with pos_x,
// pos_y, vel_x_out, vel_y_out and hit, and the result is transferred at the
// edge that ends that cycle. The receiver cannot stall, so results are never
// held back. The configuration port writes tile_pixels, map_columns and
// map_rows by index; the user must write them only while the block is idle,
// which the block itself does not enforce. Unknown indexes are ignored. Reset
// clears the box state, velocity and hit flag and restores the register reset
// values.
module aabb_collision_resolver_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic [acr_pkg::OP_BITS-1:0]              op,
	input  logic signed [acr_pkg::IN_COORD_BITS-1:0] box_x,
	input  logic signed [acr_pkg::IN_COORD_BITS-1:0] box_y,
	input  logic [acr_pkg::SIZE_BITS-1:0]            box_w,
	input  logic [acr_pkg::SIZE_BITS-1:0]            box_h,
	input  logic signed [acr_pkg::VEL_BITS-1:0]      vel_x_in,
	input  logic signed [acr_pkg::VEL_BITS-1:0]      vel_y_in,
	input  logic                                     cfg_we,
	input  logic [acr_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
	input  logic [acr_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
	output logic                                     done,
	output logic signed [acr_pkg::POS_BITS-1:0]      pos_x,
	output logic signed [acr_pkg::POS_BITS-1:0]      pos_y,
	output logic signed [acr_pkg::VEL_BITS-1:0]      vel_x_out,
	output logic signed [acr_pkg::VEL_BITS-1:0]      vel_y_out,
	output logic                                     hit
);

	acr_pkg::dp_cmd_t cmd;

	acr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.cmd    (cmd)
	);

	acr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.box_x     (box_x),
		.box_y     (box_y),
		.box_w     (box_w),
		.box_h     (box_h),
		.vel_x_in  (vel_x_in),
		.vel_y_in  (vel_y_in),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.vel_x_out (vel_x_out),
		.vel_y_out (vel_y_out),
		.hit       (hit)
	);

endmodule

// File: bench/aabb_collision_resolver_top_tb.sv
// Self-checking testbench for the box collision resolver: directed table, then random phases.
`timescale 1ns / 100ps

module aabb_collision_resolver_top_tb;
	import acr_pkg::*;

	localparam int COORD_BITS = 16;
	localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;
	localparam int RAND_ITEMS = 1880;
	localparam int PHASES = 8;
	localparam int PER_PHASE = RAND_ITEMS / PHASES;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic signed [POS_BITS-1:0] px;
		logic signed [POS_BITS-1:0] py;
		logic signed [VEL_BITS-1:0] vx;
		logic signed [VEL_BITS-1:0] vy;
		logic                       hit;
	} resolved_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [OP_BITS-1:0]              op;
		logic [IN_COORD_BITS-1:0]        x;
		logic [IN_COORD_BITS-1:0]        y;
		logic [SIZE_BITS-1:0]            w;
		logic [SIZE_BITS-1:0]            h;
		logic [VEL_BITS-1:0]             vx;
		logic [VEL_BITS-1:0]             vy;
		logic [CFG_ADDR_BITS-1:0]        addr;
		logic [CFG_DATA_BITS-1:0]        data;
		logic                            typed;
		resolved_t                       res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OP_BITS-1:0] op = OP_BEGIN;
	logic signed [IN_COORD_BITS-1:0] box_x = '0;
	logic signed [IN_COORD_BITS-1:0] box_y = '0;
	logic [SIZE_BITS-1:0] box_w = '0;
	logic [SIZE_BITS-1:0] box_h = '0;
	logic signed [VEL_BITS-1:0] vel_x_in = '0;
	logic signed [VEL_BITS-1:0] vel_y_in = '0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr = CFG_TILE_PIXELS;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic done;
	logic signed [POS_BITS-1:0] pos_x;
	logic signed [POS_BITS-1:0] pos_y;
	logic signed [VEL_BITS-1:0] vel_x_out;
	logic signed [VEL_BITS-1:0] vel_y_out;
	logic hit;

	aabb_collision_resolver_top #(.COORD_BITS(COORD_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
		.vel_x_in(vel_x_in), .vel_y_in(vel_y_in),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.done(done), .pos_x(pos_x), .pos_y(pos_y),
		.vel_x_out(vel_x_out), .vel_y_out(vel_y_out), .hit(hit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Moving box state and world registers as the block should hold them.
	longint mv_pred_x, mv_pred_y, mv_cur_x, mv_cur_y, mv_w, mv_h, mv_vx, mv_vy;
	bit mv_hit;
	longint reg_tile = 10, reg_cols = 0, reg_rows = 0;

	resolved_t pending_res[$];
	int fail_cnt = 0;
	int checked_cnt = 0;
	int hit_cnt = 0;
	int items_sent = 0;
	int settings_cnt = 0;

	function automatic longint sat_coord(input longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic bit boxes_overlap(input longint ax, ay, aw, ah, bx, by, bw, bh);
		return (ax + aw > bx) && (ax < bx + bw) && (ay + ah > by) && (ay < by + bh);
	endfunction

	function automatic bit resolve_item(input logic [OP_BITS-1:0] opc,
			input logic signed [IN_COORD_BITS-1:0] ix, iy,
			input logic [SIZE_BITS-1:0] iw, ih,
			input logic signed [VEL_BITS-1:0] ivx, ivy, output resolved_t res);
		longint ox, oy, ow, oh, world_w, world_h;
		ox = sat_coord(longint'(ix));
		oy = sat_coord(longint'(iy));
		ow = longint'(iw);
		oh = longint'(ih);
		res = '0;
		if (opc == OP_BEGIN) begin
			mv_vx = longint'(ivx);
			mv_vy = longint'(ivy);
			mv_cur_x = ox;
			mv_cur_y = oy;
			mv_w = ow;
			mv_h = oh;
			mv_pred_x = sat_coord(ox + mv_vx);
			mv_pred_y = sat_coord(oy + mv_vy);
			mv_hit = 1'b0;
			return 1'b0;
		end
		if (opc == OP_OBST) begin
			if (boxes_overlap(mv_pred_x, mv_pred_y, mv_w, mv_h, ox, oy, ow, oh)) begin
				if (boxes_overlap(mv_pred_x, mv_cur_y, mv_w, mv_h, ox, oy, ow, oh)) begin
					if (mv_vx > 0) begin
						mv_vx = 0;
						mv_cur_x = sat_coord(ox - mv_w);
					end else if (mv_vx < 0) begin
						mv_vx = 0;
						mv_cur_x = sat_coord(ox + ow);
					end
					mv_hit = 1'b1;
				end
				if (boxes_overlap(mv_cur_x, mv_pred_y, mv_w, mv_h, ox, oy, ow, oh)) begin
					if (mv_vy > 0) begin
						mv_vy = 0;
						mv_cur_y = sat_coord(oy - mv_h);
					end else if (mv_vy < 0) begin
						mv_vy = 0;
						mv_cur_y = sat_coord(oy + oh);
					end
					mv_hit = 1'b1;
				end
				if (!mv_hit) begin
					mv_vx = 0;
					mv_hit = 1'b1;
				end
			end
			return 1'b0;
		end
		if (opc == OP_FINISH) begin
			world_w = reg_cols * reg_tile;
			world_h = reg_rows * reg_tile;
			if (mv_vx < 0) begin
				if (mv_pred_x <= 0) begin
					mv_vx = 0;
					mv_cur_x = 0;
					mv_hit = 1'b1;
				end
			end else if (mv_vx > 0) begin
				if (mv_pred_x + mv_w >= world_w) begin
					mv_vx = 0;
					mv_cur_x = sat_coord(world_w - mv_w);
					mv_hit = 1'b1;
				end
			end
			if (mv_vy < 0) begin
				if (mv_pred_y <= 0) begin
					mv_vy = 0;
					mv_cur_y = 0;
					mv_hit = 1'b1;
				end
			end else if (mv_vy > 0) begin
				if (mv_pred_y + mv_h >= world_h) begin
					mv_vy = 0;
					mv_cur_y = sat_coord(world_h - mv_h);
					mv_hit = 1'b1;
				end
			end
			res.px = mv_cur_x[POS_BITS-1:0];
			res.py = mv_cur_y[POS_BITS-1:0];
			res.vx = mv_vx[VEL_BITS-1:0];
			res.vy = mv_vy[VEL_BITS-1:0];
			res.hit = mv_hit;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		resolved_t got, want;
		if (arst_n && done) begin
			got = '{pos_x, pos_y, vel_x_out, vel_y_out, hit};
			if (pending_res.size() == 0) begin
				note_fail($sformatf("unexpected result pos(%0d,%0d) vel(%0d,%0d) hit %0b",
					got.px, got.py, got.vx, got.vy, got.hit));
			end else begin
				want = pending_res.pop_front();
				checked_cnt++;
				if (got.hit) hit_cnt++;
				if (got.px !== want.px || got.py !== want.py || got.vx !== want.vx ||
						got.vy !== want.vy || got.hit !== want.hit)
					note_fail($sformatf(
						"mismatch: exp pos(%0d,%0d) vel(%0d,%0d) hit %0b, got pos(%0d,%0d) vel(%0d,%0d) hit %0b",
						want.px, want.py, want.vx, want.vy, want.hit,
						got.px, got.py, got.vx, got.vy, got.hit));
			end
		end
	end

	task automatic send_item(input logic [OP_BITS-1:0] opc,
			input logic [IN_COORD_BITS-1:0] ix, iy, input logic [SIZE_BITS-1:0] iw, ih,
			input logic [VEL_BITS-1:0] ivx, ivy, input bit typed, input resolved_t typed_res);
		resolved_t res;
		start <= 1'b1;
		op <= opc;
		box_x <= ix;
		box_y <= iy;
		box_w <= iw;
		box_h <= ih;
		vel_x_in <= ivx;
		vel_y_in <= ivy;
		do @(posedge clk); while (busy);
		if (resolve_item(opc, ix, iy, iw, ih, ivx, ivy, res))
			pending_res = {pending_res, (typed ? typed_res : res)};
		if (opc != OP_SPARE) items_sent++;
	endtask

	// Registers may only change once the block has gone quiet.
	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending_res.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_ADDR_BITS-1:0] addr,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		case (addr)
			CFG_TILE_PIXELS: reg_tile = longint'(data[TILE_BITS-1:0]);
			CFG_MAP_COLUMNS: reg_cols = longint'(data[MAP_BITS-1:0]);
			CFG_MAP_ROWS: reg_rows = longint'(data[MAP_BITS-1:0]);
			default: ;
		endcase
		if (addr == CFG_MAP_ROWS) settings_cnt++;
	endtask

	task automatic sender_gap(input int pct);
		if (pct != 0 && $urandom_range(99) < pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	row_t dir_rows[$] = '{
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}},
		'{ROW_ITEM, OP_OBST, -5, -5, 10, 10, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1}},
		'{ROW_ITEM, OP_SPARE, 1234, -77, 4095, 4095, -128, 127, 0, 0, 0, '0},
		'{ROW_ITEM, OP_BEGIN, 32767, -32768, 4095, 4095, 127, -128, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{-4095, 0, 0, 0, 1}},
		'{ROW_ITEM, OP_FINISH, -1, -1, 4095, 4095, -1, -1, 0, 0, 1, '{-4095, 0, 0, 0, 1}},
		'{ROW_ITEM, OP_BEGIN, 100, 100, 10, 10, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_OBST, 105, 105, 10, 10, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 1, '{100, 100, 0, 0, 1}},
		'{ROW_CFG, OP_BEGIN, 0, 0, 0, 0, 0, 0, CFG_TILE_PIXELS, 255, 0, '0},
		'{ROW_CFG, OP_BEGIN, 0, 0, 0, 0, 0, 0, CFG_MAP_COLUMNS, 1023, 0, '0},
		'{ROW_CFG, OP_BEGIN, 0, 0, 0, 0, 0, 0, CFG_MAP_ROWS, 1023, 0, '0},
		'{ROW_ITEM, OP_BEGIN, 0, 0, 10, 10, 5, 5, 0, 0, 0, '0},
		'{ROW_ITEM, OP_OBST, 12, 12, 10, 10, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_BEGIN, 50, 0, 10, 10, -8, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_OBST, 40, 0, 5, 10, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_BEGIN, 0, 50, 10, 10, 0, -8, 0, 0, 0, '0},
		'{ROW_ITEM, OP_OBST, 0, 40, 10, 5, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0},
		'{ROW_ITEM, OP_BEGIN, 32760, 32760, 0, 0, 127, 127, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0},
		'{ROW_CFG, OP_BEGIN, 0, 0, 0, 0, 0, 0, CFG_TILE_PIXELS, 1, 0, '0},
		'{ROW_CFG, OP_BEGIN, 0, 0, 0, 0, 0, 0, CFG_MAP_COLUMNS, 5, 0, '0},
		'{ROW_CFG, OP_BEGIN, 0, 0, 0, 0, 0, 0, CFG_MAP_ROWS, 5, 0, '0},
		'{ROW_ITEM, OP_BEGIN, -32768, 32767, 0, 4095, -128, 127, 0, 0, 0, '0},
		'{ROW_ITEM, OP_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0}
	};

	initial begin
		int dir_items, pct, phase_base, n_obst;
		int mx, my, mw, mh, mvx, mvy, tile, cols, rows;
		bit paused;
		mv_pred_x = 0; mv_pred_y = 0; mv_cur_x = 0; mv_cur_y = 0;
		mv_w = 0; mv_h = 0; mv_vx = 0; mv_vy = 0; mv_hit = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!cfg_we) wait_quiet();
				reg_write(dir_rows[i].addr, dir_rows[i].data);
			end else begin
				cfg_we <= 1'b0;
				send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
					dir_rows[i].h, dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].typed,
					dir_rows[i].res);
			end
		end
		dir_items = items_sent;

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin tile = 1; cols = 0; rows = 0; end
				1: begin tile = 255; cols = 1023; rows = 1023; end
				2: begin tile = 10; cols = 100; rows = 80; end
				default: begin
					tile = $urandom_range(1, 40);
					cols = $urandom_range(0, 120);
					rows = $urandom_range(0, 120);
				end
			endcase
			case (p % 3)
				0: pct = 0;
				1: pct = 87;
				default: pct = 13;
			endcase
			wait_quiet();
			reg_write(CFG_TILE_PIXELS, CFG_DATA_BITS'(tile));
			reg_write(CFG_MAP_COLUMNS, CFG_DATA_BITS'(cols));
			reg_write(CFG_MAP_ROWS, CFG_DATA_BITS'(rows));
			cfg_we <= 1'b0;
			phase_base = dir_items + p * PER_PHASE;
			paused = 1'b0;
			while (items_sent < phase_base + PER_PHASE) begin
				if (!paused && items_sent >= phase_base + PER_PHASE / 2) begin
					start <= 1'b0;
					do @(posedge clk); while (pending_res.size() != 0);
					paused = 1'b1;
				end
				if ($urandom_range(99) < 85) begin
					mx = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) - 32768
						: int'($urandom_range(1400)) - 200;
					my = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) - 32768
						: int'($urandom_range(1400)) - 200;
					mw = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(40);
					mh = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(40);
					mvx = int'($urandom_range(255)) - 128;
					mvy = int'($urandom_range(255)) - 128;
					sender_gap(pct);
					send_item(OP_BEGIN, 16'(mx), 16'(my), 12'(mw), 12'(mh), 8'(mvx), 8'(mvy),
						1'b0, '0);
					n_obst = $urandom_range(0, 4);
					for (int k = 0; k < n_obst; k++) begin
						sender_gap(pct);
						send_item(OP_OBST, 16'(mx + mvx + int'($urandom_range(120)) - 60),
							16'(my + mvy + int'($urandom_range(120)) - 60),
							12'($urandom_range(40)), 12'($urandom_range(40)),
							8'($urandom), 8'($urandom), 1'b0, '0);
					end
					sender_gap(pct);
					send_item(OP_FINISH, 16'($urandom), 16'($urandom), 12'($urandom),
						12'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
				end else begin
					sender_gap(pct);
					send_item(OP_BITS'($urandom_range(3)), 16'($urandom), 16'($urandom),
						12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
				end
			end
		end

		start <= 1'b0;
		for (int k = 0; k < 1000 && pending_res.size() != 0; k++) @(posedge clk);
		repeat (8) @(posedge clk);
		while (pending_res.size() != 0) begin
			void'(pending_res.pop_front());
			note_fail("expected result never arrived");
		end

		$display("Covered %0d items (%0d from the directed table) over %0d world settings.",
			items_sent, dir_items, settings_cnt);
		$display("Checked %0d results, %0d of them with a collision; %0d failures.",
			checked_cnt, hit_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("aabb_collision_resolver_top regression: pass");
		else
			$display("aabb_collision_resolver_top regression: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timed out waiting for a transfer.");
		$display("aabb_collision_resolver_top regression: fail");
		$finish;
	end

endmodule

// File: aabb_collision_resolver_top.f
rtl/core/acr_pkg.sv
rtl/core/acr_ctrl.sv
rtl/core/acr_datapath.sv
rtl/core/aabb_collision_resolver_top.sv
bench/aabb_collision_resolver_top_tb.sv
